### rtl/core/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define CCE_ASSERT_AT(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error("cce check failed");

// Same, on the house clock and reset names.
`define CCE_ASSERT(lbl, prop) \
	`CCE_ASSERT_AT(lbl, clk, arst_n, prop)

`endif

### rtl/core/cce_pkg.sv
package cce_pkg;

	localparam logic [7:0] CrcPoly    = 8'h8C;
	localparam int         LevelStep  = 51;
	localparam int         LevelCount = 5;
	localparam logic [7:0] HdrShort   = 8'h91;
	localparam logic [7:0] HdrLong    = 8'h94;
	localparam logic [7:0] FrameSep   = 8'h0E;
	localparam logic [7:0] RightMark  = 8'h80;
	localparam int         FrameMax   = 6;
	localparam logic [2:0] LenShort   = 3'd4;
	localparam logic [2:0] LenLong    = 3'd6;

	typedef struct packed {
		logic [7:0] left_red;
		logic [7:0] left_green;
		logic [7:0] left_blue;
		logic [7:0] right_red;
		logic [7:0] right_green;
		logic [7:0] right_blue;
	} color_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_item_t;

	// What the serializer needs to lay out one frame.
	typedef struct packed {
		logic       is_short;
		logic [7:0] lcode;
		logic [7:0] rbyte;
		logic [7:0] crc;
	} frame_desc_t;

	// Indexed [red][green][blue], flattened as r*25 + g*5 + b.
	localparam logic [7:0] ColorTable [0:124] = '{
		8'h1D, 8'h1D, 8'h04, 8'h04, 8'h04,  8'h04, 8'h04, 8'h02, 8'h02, 8'h02,
		8'h02, 8'h02, 8'h01, 8'h01, 8'h01,  8'h01, 8'h01, 8'h1A, 8'h1A, 8'h1A,
		8'h1A, 8'h17, 8'h17, 8'h17, 8'h16,
		8'h16, 8'h16, 8'h16, 8'h16, 8'h07,  8'h07, 8'h07, 8'h07, 8'h07, 8'h07,
		8'h07, 8'h07, 8'h07, 8'h07, 8'h07,  8'h07, 8'h07, 8'h07, 8'h08, 8'h08,
		8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
		8'h08, 8'h08, 8'h08, 8'h08, 8'h08,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
		8'h08, 8'h08, 8'h08, 8'h08, 8'h08,  8'h08, 8'h08, 8'h08, 8'h08, 8'h06,
		8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
		8'h06, 8'h06, 8'h06, 8'h06, 8'h06,  8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
		8'h06, 8'h06, 8'h06, 8'h06, 8'h06,  8'h06, 8'h06, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h15, 8'h0D, 8'h0D, 8'h0C, 8'h0A,  8'h10, 8'h10, 8'h10, 8'h10, 8'h10,
		8'h11, 8'h11, 8'h11, 8'h11, 8'h11,  8'h0F, 8'h0F, 8'h05, 8'h05, 8'h05,
		8'h12, 8'h12, 8'h1B, 8'h1B, 8'h1C
	};

	// Channel / 51, clamped to 4: count the thresholds crossed.
	function automatic logic [2:0] level(input logic [7:0] v);
		logic [2:0] lvl;
		lvl = 3'd0;
		for (int i = 1; i < LevelCount; i++) begin
			if (v >= 8'(LevelStep * i)) begin
				lvl = lvl + 3'd1;
			end
		end
		return lvl;
	endfunction

	function automatic logic [7:0] color_code(input logic [2:0] r, input logic [2:0] g,
	                                          input logic [2:0] b);
		logic [6:0] idx;
		idx = 7'(r * 7'd25) + 7'(g * 7'd5) + 7'(b);
		return ColorTable[idx];
	endfunction

	// Reflected CRC-8, one byte.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

	// CRC after the two fixed leading bytes of each frame kind.
	localparam logic [7:0] CrcShortPre = crc8_byte(crc8_byte(8'h00, HdrShort), FrameSep);
	localparam logic [7:0] CrcLongPre  = crc8_byte(crc8_byte(8'h00, HdrLong), FrameSep);

endpackage

### rtl/core/cce_serializer.sv
module cce_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	output logic                 load_ready,
	input  cce_pkg::frame_desc_t load,
	output logic                 frame_valid,
	input  logic                 frame_ready,
	output cce_pkg::frame_item_t frame
);
	import cce_pkg::*;

	logic [7:0] buf_q [FrameMax];
	logic [2:0] cnt_q;
	logic       take;
	logic       last;
	logic       do_load;

	assign last        = (cnt_q == 3'd1);
	assign take        = frame_valid && frame_ready;
	assign frame_valid = (cnt_q != 3'd0);
	assign load_ready  = (cnt_q == 3'd0) || (take && last);
	assign do_load     = load_valid && load_ready;

	assign frame.frame_byte = buf_q[0];
	assign frame.frame_end  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (do_load) begin
			cnt_q <= load.is_short ? LenShort : LenLong;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			buf_q[0] <= load.is_short ? HdrShort : HdrLong;
			buf_q[1] <= FrameSep;
			buf_q[2] <= load.lcode;
			buf_q[3] <= load.is_short ? load.crc : FrameSep;
			buf_q[4] <= load.rbyte;
			buf_q[5] <= load.crc;
		end else if (take) begin
			for (int i = 0; i < FrameMax - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

endmodule

### rtl/core/color_command_frame_encoder.sv
// channel | handshake                 | payload
// color   | color_valid / color_ready | cce_pkg::color_item_t, two RGB colors
// frame   | frame_valid / frame_ready | cce_pkg::frame_item_t, one frame byte
//
// Five register stages: quantize, table lookup, then three CRC byte steps.
// A 6-byte shift buffer then sends 4 bytes (equal quantized colors) or 6 bytes per item,
// so the byte output sets the sustained rate; the stages can take further colors while it sends.
// An accepted color passes the quantize, lookup and three CRC stages, then loads the buffer.
// Async reset empties all stages and the buffer; stalls freeze each full stage.
module color_command_frame_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 color_valid,
	output logic                 color_ready,
	input  cce_pkg::color_item_t color,
	output logic                 frame_valid,
	input  logic                 frame_ready,
	output cce_pkg::frame_item_t frame
);
	import cce_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic ser_ready;

	logic [2:0] lr_s1, lg_s1, lb_s1, rr_s1, rg_s1, rb_s1;
	logic [7:0] lcode_s2, rcode_s2;
	logic       short_s2, short_s3, short_s4, short_s5;
	logic [7:0] lcode_s3, lcode_s4, lcode_s5;
	logic [7:0] rbyte_s3, rbyte_s4, rbyte_s5;
	logic [7:0] crc_s3, crc_s4, crc_s5;

	frame_desc_t desc;

	assign en5         = !v_s5 || ser_ready;
	assign en4         = !v_s4 || en5;
	assign en3         = !v_s3 || en4;
	assign en2         = !v_s2 || en3;
	assign en1         = !v_s1 || en2;
	assign color_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= color_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			lr_s1 <= level(color.left_red);
			lg_s1 <= level(color.left_green);
			lb_s1 <= level(color.left_blue);
			rr_s1 <= level(color.right_red);
			rg_s1 <= level(color.right_green);
			rb_s1 <= level(color.right_blue);
		end
		if (en2) begin
			lcode_s2 <= color_code(lr_s1, lg_s1, lb_s1);
			rcode_s2 <= color_code(rr_s1, rg_s1, rb_s1);
			short_s2 <= (lr_s1 == rr_s1) && (lg_s1 == rg_s1) && (lb_s1 == rb_s1);
		end
		if (en3) begin
			lcode_s3 <= lcode_s2;
			rbyte_s3 <= rcode_s2 + RightMark;
			short_s3 <= short_s2;
			crc_s3   <= crc8_byte(short_s2 ? CrcShortPre : CrcLongPre, lcode_s2);
		end
		// short frames are done after the code byte; long ones take two more
		if (en4) begin
			lcode_s4 <= lcode_s3;
			rbyte_s4 <= rbyte_s3;
			short_s4 <= short_s3;
			crc_s4   <= short_s3 ? crc_s3 : crc8_byte(crc_s3, FrameSep);
		end
		if (en5) begin
			lcode_s5 <= lcode_s4;
			rbyte_s5 <= rbyte_s4;
			short_s5 <= short_s4;
			crc_s5   <= short_s4 ? crc_s4 : crc8_byte(crc_s4, rbyte_s4);
		end
	end

	assign desc.is_short = short_s5;
	assign desc.lcode    = lcode_s5;
	assign desc.rbyte    = rbyte_s5;
	assign desc.crc      = crc_s5;

	cce_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (v_s5),
		.load_ready  (ser_ready),
		.load        (desc),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

endmodule

### rtl/core/cce_checker.sv
`include "assert_macros.svh"

module cce_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 color_valid,
	input logic                 color_ready,
	input logic                 frame_valid,
	input logic                 frame_ready,
	input cce_pkg::frame_item_t frame
);
	import cce_pkg::*;

	logic [2:0] pos_q;
	logic       take;
	logic       in_take;

	assign take    = frame_valid && frame_ready;
	assign in_take = color_valid && color_ready;

	// byte position within the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
		end else if (take) begin
			pos_q <= frame.frame_end ? 3'd0 : pos_q + 3'd1;
		end
	end

	`CCE_ASSERT(a_out_hold, frame_valid && !frame_ready |=> frame_valid && $stable(frame))
	`CCE_ASSERT(a_header, frame_valid && pos_q == 3'd0 |-> frame.frame_byte == HdrShort || frame.frame_byte == HdrLong)
	`CCE_ASSERT(a_sep, frame_valid && pos_q == 3'd1 |-> frame.frame_byte == FrameSep)
	`CCE_ASSERT(a_end_pos, frame_valid && frame.frame_end |-> pos_q == 3'd3 || pos_q == 3'd5)
	`CCE_ASSERT(a_stall_cause, !color_ready |-> frame_valid && !$isunknown(in_take))

endmodule

bind color_command_frame_encoder cce_checker u_cce_checker (.*);
